[rtl/core/ucko_pkg.sv]
`default_nettype none

package ucko_pkg;

   // Fixed widths of the pixel, index, register and counter fields, and the side limit.
   localparam int unsigned PIXEL_W      = 16;
   localparam int unsigned INDEX_W      = 12;
   localparam int unsigned SIDE_REG_W   = 9;
   localparam int unsigned DUP_REG_W    = 7;
   localparam int unsigned OVER_CNT_W   = 8;
   localparam int unsigned SIZE_PROD_W  = 2 * SIDE_REG_W;
   localparam int unsigned ADDR_CALC_W  = OVER_CNT_W + SIDE_REG_W + 1;
   localparam int unsigned MAX_SIDE     = 256;

   // Configuration port geometry.
   localparam int unsigned CSR_INDEX_W  = 3;
   localparam int unsigned CSR_DATA_W   = 16;

   // Stream payload geometry.
   localparam int unsigned REQ_TDATA_W  = 48;
   localparam int unsigned REQ_TUSER_W  = 2;
   localparam int unsigned RSP_TDATA_W  = 16;
   localparam int unsigned RSP_TUSER_W  = 2;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_OVERLAY_WIDTH   = 3'd0,
      CSR_OVERLAY_HEIGHT  = 3'd1,
      CSR_DUP_X           = 3'd2,
      CSR_DUP_Y           = 3'd3,
      CSR_CHECKER_MODE    = 3'd4,
      CSR_TRANSPARENT_KEY = 3'd5,
      CSR_PROTECTED_VALUE = 3'd6
   } csr_index_type;

   // Request kinds carried in tuser bit 0.
   localparam logic ACTION_LOAD  = 1'b0;
   localparam logic ACTION_PIXEL = 1'b1;

   // Effective configuration as seen by the datapath.
   typedef struct packed {
      logic [SIDE_REG_W-1:0] overlay_width;
      logic [SIDE_REG_W-1:0] overlay_height;
      logic [DUP_REG_W-1:0]  dup_x;
      logic [DUP_REG_W-1:0]  dup_y;
      logic                  checker_mode;
      logic [PIXEL_W-1:0]    transparent_key;
      logic [PIXEL_W-1:0]    protected_value;
      logic                  size_bad;
   } cfg_type;

   // Per-pixel facts from the raster position.
   typedef struct packed {
      logic in_range;
      logic pos_ok;
      logic last;
   } raster_info_type;

endpackage

`default_nettype wire

[rtl/core/ucko_ram.sv]
`default_nettype none

module ucko_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port; read data holds between reads.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/core/ucko_cfg.sv]
`default_nettype none

module ucko_cfg #(
   parameter int unsigned OVERLAY_CAPACITY = 4096,
   parameter int unsigned MAX_DUP          = 64
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_we,
   input  wire logic [ucko_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [ucko_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output ucko_pkg::cfg_type                        cfg
);

   localparam int unsigned CMP_W = ucko_pkg::DUP_REG_W + 2;

   logic [ucko_pkg::SIDE_REG_W-1:0]  width_ff;
   logic [ucko_pkg::SIDE_REG_W-1:0]  height_ff;
   logic [ucko_pkg::DUP_REG_W-1:0]   dup_x_ff;
   logic [ucko_pkg::DUP_REG_W-1:0]   dup_y_ff;
   logic                             checker_ff;
   logic [ucko_pkg::PIXEL_W-1:0]     key_ff;
   logic [ucko_pkg::PIXEL_W-1:0]     protect_ff;
   logic [ucko_pkg::SIZE_PROD_W-1:0] area;

   // Register file; writes to unused indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= '0;
         height_ff  <= '0;
         dup_x_ff   <= ucko_pkg::DUP_REG_W'(1);
         dup_y_ff   <= ucko_pkg::DUP_REG_W'(1);
         checker_ff <= 1'b0;
         key_ff     <= '0;
         protect_ff <= '0;
      end else if (csr_we) begin
         unique case (ucko_pkg::csr_index_type'(csr_index))
            ucko_pkg::CSR_OVERLAY_WIDTH: begin
               width_ff <= csr_wdata[ucko_pkg::SIDE_REG_W-1:0];
            end
            ucko_pkg::CSR_OVERLAY_HEIGHT: begin
               height_ff <= csr_wdata[ucko_pkg::SIDE_REG_W-1:0];
            end
            ucko_pkg::CSR_DUP_X: begin
               dup_x_ff <= csr_wdata[ucko_pkg::DUP_REG_W-1:0];
            end
            ucko_pkg::CSR_DUP_Y: begin
               dup_y_ff <= csr_wdata[ucko_pkg::DUP_REG_W-1:0];
            end
            ucko_pkg::CSR_CHECKER_MODE: begin
               checker_ff <= csr_wdata[0];
            end
            ucko_pkg::CSR_TRANSPARENT_KEY: begin
               key_ff <= csr_wdata;
            end
            ucko_pkg::CSR_PROTECTED_VALUE: begin
               protect_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // A duplication factor of zero acts as one; large ones saturate at the maximum.
   function automatic logic [ucko_pkg::DUP_REG_W-1:0] clamp_dup(
      input logic [ucko_pkg::DUP_REG_W-1:0] d
   );
      logic [ucko_pkg::DUP_REG_W-1:0] r;
      r = d;
      if (d == '0) begin
         r = ucko_pkg::DUP_REG_W'(1);
      end else if (CMP_W'(d) > CMP_W'(MAX_DUP)) begin
         r = ucko_pkg::DUP_REG_W'(MAX_DUP);
      end
      return r;
   endfunction

   // Overlay size check against zero sides, the side limit and the store capacity.
   assign area = ucko_pkg::SIZE_PROD_W'(width_ff) * ucko_pkg::SIZE_PROD_W'(height_ff);

   always_comb begin
      cfg.overlay_width   = width_ff;
      cfg.overlay_height  = height_ff;
      cfg.dup_x           = clamp_dup(dup_x_ff);
      cfg.dup_y           = clamp_dup(dup_y_ff);
      cfg.checker_mode    = checker_ff;
      cfg.transparent_key = key_ff;
      cfg.protected_value = protect_ff;
      cfg.size_bad        = (width_ff == '0) || (height_ff == '0)
                         || (width_ff > ucko_pkg::SIDE_REG_W'(ucko_pkg::MAX_SIDE))
                         || (height_ff > ucko_pkg::SIDE_REG_W'(ucko_pkg::MAX_SIDE))
                         || (area > ucko_pkg::SIZE_PROD_W'(OVERLAY_CAPACITY));
   end

endmodule

`default_nettype wire

[rtl/core/ucko_raster.sv]
`default_nettype none

module ucko_raster #(
   parameter int unsigned OVERLAY_CAPACITY = 4096,
   parameter int unsigned MAX_DUP          = 64
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire ucko_pkg::cfg_type                     cfg,
   input  wire logic                                  advance,
   input  wire logic                                  frame_start,
   output logic [$clog2(OVERLAY_CAPACITY)-1:0]        rd_addr,
   output ucko_pkg::raster_info_type                  info
);

   localparam int unsigned SUB_W  = $clog2(MAX_DUP);
   localparam int unsigned CMP_W  = (SUB_W + 1 > ucko_pkg::DUP_REG_W) ?
                                    SUB_W + 1 : ucko_pkg::DUP_REG_W;
   localparam int unsigned OVC_W  = ucko_pkg::OVER_CNT_W;
   localparam int unsigned SIDE_W = ucko_pkg::SIDE_REG_W;
   localparam int unsigned AW     = $clog2(OVERLAY_CAPACITY);

   logic [SUB_W-1:0] sub_col_ff, sub_col_in, sub_row_ff, sub_row_in;
   logic [OVC_W-1:0] over_col_ff, over_col_in, over_row_ff, over_row_in;
   logic [SUB_W-1:0] base_sc, base_sr;
   logic [OVC_W-1:0] base_oc, base_or;
   logic [CMP_W-1:0] sc1, sr1, dx, dy;
   logic [SIDE_W-1:0] oc1, or1;
   logic [ucko_pkg::ADDR_CALC_W-1:0] addr_full;

   // Frame start clears the position before this pixel is looked at.
   always_comb begin
      base_sc = frame_start ? '0 : sub_col_ff;
      base_sr = frame_start ? '0 : sub_row_ff;
      base_oc = frame_start ? '0 : over_col_ff;
      base_or = frame_start ? '0 : over_row_ff;
   end

   // Incremented positions and bounds in comparison widths.
   always_comb begin
      sc1 = CMP_W'(base_sc) + CMP_W'(1);
      sr1 = CMP_W'(base_sr) + CMP_W'(1);
      oc1 = SIDE_W'(base_oc) + SIDE_W'(1);
      or1 = SIDE_W'(base_or) + SIDE_W'(1);
      dx  = CMP_W'(cfg.dup_x);
      dy  = CMP_W'(cfg.dup_y);
   end

   // Store address of the overlay entry under the current pixel.
   assign addr_full = ucko_pkg::ADDR_CALC_W'(base_or) * ucko_pkg::ADDR_CALC_W'(cfg.overlay_width)
                    + ucko_pkg::ADDR_CALC_W'(base_oc);
   assign rd_addr   = addr_full[AW-1:0];

   // Per-pixel flags from the position.
   always_comb begin
      info.in_range = (SIDE_W'(base_oc) < cfg.overlay_width)
                   && (SIDE_W'(base_or) < cfg.overlay_height);
      info.pos_ok   = !cfg.checker_mode || !(base_sc[0] ^ base_sr[0]);
      info.last     = (oc1 == cfg.overlay_width) && (sc1 == dx)
                   && (or1 == cfg.overlay_height) && (sr1 == dy);
   end

   // Nested raster counters: sub column, overlay column, sub row, overlay row.
   always_comb begin
      sub_col_in  = base_sc;
      sub_row_in  = base_sr;
      over_col_in = base_oc;
      over_row_in = base_or;
      if (!cfg.size_bad) begin
         if (sc1 >= dx) begin
            sub_col_in = '0;
            if (oc1 >= cfg.overlay_width) begin
               over_col_in = '0;
               if (sr1 >= dy) begin
                  sub_row_in = '0;
                  if (or1 >= cfg.overlay_height) begin
                     over_row_in = '0;
                  end else begin
                     over_row_in = or1[OVC_W-1:0];
                  end
               end else begin
                  sub_row_in = sr1[SUB_W-1:0];
               end
            end else begin
               over_col_in = oc1[OVC_W-1:0];
            end
         end else begin
            sub_col_in = sc1[SUB_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_col_ff  <= '0;
         sub_row_ff  <= '0;
         over_col_ff <= '0;
         over_row_ff <= '0;
      end else if (advance) begin
         sub_col_ff  <= sub_col_in;
         sub_row_ff  <= sub_row_in;
         over_col_ff <= over_col_in;
         over_row_ff <= over_row_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/upscaled_color_key_overlay_unit.sv]
`default_nettype none

// Color-keyed overlay with nearest-neighbor upscaling. Load requests (tuser bit 0 low) write
// one entry of the overlay store; pixel requests (tuser bit 0 high) stream the image in raster
// order, tuser bit 1 marking the first pixel of a frame, and each returns one response with
// the overlaid pixel, the replace flag, the size status and tlast on the frame's final pixel.
// The unit takes one request per clock while the response side is not stalled; a pixel passes
// through the lookup stage, beside the store's registered read, and then the output register.
// Overlay entries must be loaded before the pixels that use them; the store is not cleared.
module upscaled_color_key_overlay_unit #(
   parameter int unsigned OVERLAY_CAPACITY = 4096,
   parameter int unsigned MAX_DUP          = 64
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // Request stream.
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // tdata: overlay_index[11:0], overlay_value[27:12], image_pixel[43:28], zero fill.
   input  wire logic [ucko_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // tuser: action[0], frame_start[1].
   input  wire logic [ucko_pkg::REQ_TUSER_W-1:0]    req_tuser,
   // Response stream.
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // tdata: pixel_out[15:0].
   output logic [ucko_pkg::RSP_TDATA_W-1:0]         rsp_tdata,
   // tuser: was_overlaid[0], status[1].
   output logic [ucko_pkg::RSP_TUSER_W-1:0]         rsp_tuser,
   output logic                                     rsp_tlast,
   // Configuration writes.
   input  wire logic                                csr_we,
   input  wire logic [ucko_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [ucko_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int unsigned AW    = $clog2(OVERLAY_CAPACITY);
   localparam int unsigned CAP_W = $clog2(OVERLAY_CAPACITY + 1);
   localparam int unsigned IDX_W = (CAP_W > ucko_pkg::INDEX_W) ? CAP_W : ucko_pkg::INDEX_W;
   localparam int unsigned PW    = ucko_pkg::PIXEL_W;

   ucko_pkg::cfg_type         cfg;
   ucko_pkg::raster_info_type info;

   logic                      req_fire, pixel_fire, load_fire;
   logic [ucko_pkg::INDEX_W-1:0] req_index;
   logic [PW-1:0]             req_value, req_pixel;
   logic                      req_action, req_frame_start;
   logic [IDX_W-1:0]          index_ext;
   logic [AW-1:0]             rd_addr;
   logic [PW-1:0]             ram_rdata;
   logic                      rsp_free, s1_move;

   logic                      s1_valid_ff, s1_valid_in;
   logic [PW-1:0]             s1_pixel_ff;
   logic                      s1_hit_pre_ff, s1_bad_ff, s1_last_ff;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [PW-1:0]             rsp_pixel_ff;
   logic                      rsp_hit_ff, rsp_status_ff, rsp_last_ff;
   logic                      s1_hit;

   // Request field unpacking.
   always_comb begin
      req_index       = req_tdata[ucko_pkg::INDEX_W-1:0];
      req_value       = req_tdata[ucko_pkg::INDEX_W +: PW];
      req_pixel       = req_tdata[ucko_pkg::INDEX_W + PW +: PW];
      req_action      = req_tuser[0];
      req_frame_start = req_tuser[1];
   end

   // Handshake: the input stage moves when the output register is free or being emptied.
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign s1_move    = s1_valid_ff && rsp_free;
   assign req_tready = !s1_valid_ff || rsp_free;
   assign req_fire   = req_tvalid && req_tready;
   assign pixel_fire = req_fire && (req_action == ucko_pkg::ACTION_PIXEL);
   assign load_fire  = req_fire && (req_action == ucko_pkg::ACTION_LOAD);

   // Loads beyond the store are dropped.
   assign index_ext = IDX_W'(req_index);

   ucko_cfg #(
      .OVERLAY_CAPACITY (OVERLAY_CAPACITY),
      .MAX_DUP          (MAX_DUP)
   ) u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ucko_raster #(
      .OVERLAY_CAPACITY (OVERLAY_CAPACITY),
      .MAX_DUP          (MAX_DUP)
   ) u_raster (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .advance     (pixel_fire),
      .frame_start (req_frame_start),
      .rd_addr     (rd_addr),
      .info        (info)
   );

   ucko_ram #(
      .WIDTH (PW),
      .DEPTH (OVERLAY_CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (load_fire && (index_ext < IDX_W'(OVERLAY_CAPACITY))),
      .wr_addr (index_ext[AW-1:0]),
      .wr_data (req_value),
      .rd_en   (pixel_fire),
      .rd_addr (rd_addr),
      .rd_data (ram_rdata)
   );

   // Lookup stage: holds the pixel while the store read completes.
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = pixel_fire;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pixel_fire) begin
         s1_pixel_ff   <= req_pixel;
         s1_bad_ff     <= cfg.size_bad;
         s1_last_ff    <= info.last && !cfg.size_bad;
         s1_hit_pre_ff <= !cfg.size_bad && info.in_range && info.pos_ok
                       && (req_pixel != cfg.protected_value);
      end
   end

   // Key compare on the overlay entry.
   assign s1_hit = s1_hit_pre_ff && (ram_rdata != cfg.transparent_key);

   // Output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_pixel_ff  <= s1_hit ? ram_rdata : s1_pixel_ff;
         rsp_hit_ff    <= s1_hit;
         rsp_status_ff <= s1_bad_ff;
         rsp_last_ff   <= s1_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_pixel_ff;
   assign rsp_tuser  = {rsp_status_ff, rsp_hit_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

[verif/ucko_overlay_checker.sv]
module ucko_overlay_checker #(
   parameter int unsigned OVERLAY_CAPACITY = 4096,
   parameter int unsigned MAX_DUP          = 64
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   input  wire logic                                req_tready,
   // tdata: overlay_index[11:0], overlay_value[27:12], image_pixel[43:28], zero fill.
   input  wire logic [ucko_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // tuser: action[0], frame_start[1].
   input  wire logic [ucko_pkg::REQ_TUSER_W-1:0]    req_tuser,
   input  wire logic                                rsp_tvalid,
   input  wire logic                                rsp_tready,
   // tdata: pixel_out[15:0].
   input  wire logic [ucko_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // tuser: was_overlaid[0], status[1].
   input  wire logic [ucko_pkg::RSP_TUSER_W-1:0]    rsp_tuser,
   input  wire logic                                rsp_tlast,
   input  wire logic                                csr_we,
   input  wire logic [ucko_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [ucko_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output int                                       fail_count,
   output int                                       pending
);
   timeunit 1ns;
   timeprecision 1ps;

   import ucko_pkg::*;

   // One predicted response of a pixel request.
   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic               overlaid;
      logic               size_error;
      logic               frame_last;
   } pixel_outcome_type;

   // Shadow configuration, reset to the register defaults.
   logic [SIDE_REG_W-1:0] ov_width;
   logic [SIDE_REG_W-1:0] ov_height;
   logic [DUP_REG_W-1:0]  rep_x;
   logic [DUP_REG_W-1:0]  rep_y;
   logic                  checker_on;
   logic [PIXEL_W-1:0]    key_value;
   logic [PIXEL_W-1:0]    guard_value;

   // Shadow raster position and overlay store.
   int unsigned           sub_x;
   int unsigned           sub_y;
   int unsigned           tile_x;
   int unsigned           tile_y;
   logic [PIXEL_W-1:0]    overlay_mem [OVERLAY_CAPACITY];

   pixel_outcome_type     outcomes [$];

   initial begin
      fail_count = 0;
      pending = 0;
   end

   // Replication factors of zero act as one; oversized ones saturate.
   function automatic int unsigned effective_rep(input logic [DUP_REG_W-1:0] r);
      if (r == '0) return 1;
      if (32'(r) > MAX_DUP) return MAX_DUP;
      return 32'(r);
   endfunction

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      $display("[%0t] mismatch in %s: got %h, expected %h", $time, what, got, want);
      fail_count++;
   endtask

   task automatic load_register(input logic [CSR_INDEX_W-1:0] idx,
                                input logic [CSR_DATA_W-1:0] value);
      case (csr_index_type'(idx))
         CSR_OVERLAY_WIDTH:   ov_width    = value[SIDE_REG_W-1:0];
         CSR_OVERLAY_HEIGHT:  ov_height   = value[SIDE_REG_W-1:0];
         CSR_DUP_X:           rep_x       = value[DUP_REG_W-1:0];
         CSR_DUP_Y:           rep_y       = value[DUP_REG_W-1:0];
         CSR_CHECKER_MODE:    checker_on  = value[0];
         CSR_TRANSPARENT_KEY: key_value   = value[PIXEL_W-1:0];
         CSR_PROTECTED_VALUE: guard_value = value[PIXEL_W-1:0];
         default: ;
      endcase
   endtask

   // Works out the response of one pixel and advances the raster position.
   task automatic predict_pixel(input logic [PIXEL_W-1:0] pix, input logic fs,
                                output pixel_outcome_type res);
      int unsigned w;
      int unsigned h;
      int unsigned dx;
      int unsigned dy;
      int unsigned addr;
      int unsigned nxt;
      logic [PIXEL_W-1:0] entry;
      logic pos_even;
      w = 32'(ov_width);
      h = 32'(ov_height);
      dx = effective_rep(rep_x);
      dy = effective_rep(rep_y);
      res = '{pixel: pix, overlaid: 1'b0, size_error: 1'b0, frame_last: 1'b0};
      if (fs) begin
         sub_x = 0;
         sub_y = 0;
         tile_x = 0;
         tile_y = 0;
      end
      if (w == 0 || h == 0 || w > MAX_SIDE || h > MAX_SIDE || w * h > OVERLAY_CAPACITY) begin
         // Bad overlay size: pass through with error status, position frozen.
         res.size_error = 1'b1;
      end else begin
         // A position left beyond the overlay by a size change passes through.
         if (tile_x < w && tile_y < h) begin
            addr = tile_y * w + tile_x;
            if (addr < OVERLAY_CAPACITY) begin
               entry = overlay_mem[addr];
               pos_even = !checker_on || (((sub_x + sub_y) & 1) == 0);
               if (entry != key_value && pos_even && pix != guard_value) begin
                  res.pixel = entry;
                  res.overlaid = 1'b1;
               end
            end
         end
         res.frame_last = (tile_x == w - 1) && (sub_x == dx - 1) &&
                          (tile_y == h - 1) && (sub_y == dy - 1);
         // Step through the replicated block, then the overlay row, then the rows.
         nxt = sub_x + 1;
         if (nxt >= dx) begin
            sub_x = 0;
            nxt = tile_x + 1;
            if (nxt >= w) begin
               tile_x = 0;
               nxt = sub_y + 1;
               if (nxt >= dy) begin
                  sub_y = 0;
                  nxt = tile_y + 1;
                  if (nxt >= h) tile_y = 0;
                  else tile_y = nxt;
               end else begin
                  sub_y = nxt;
               end
            end else begin
               tile_x = nxt;
            end
         end else begin
            sub_x = nxt;
         end
      end
   endtask

   task automatic check_response();
      pixel_outcome_type want;
      if (outcomes.size() == 0) begin
         report_mismatch("response with no pixel outstanding", rsp_tdata, '0);
      end else begin
         want = outcomes.pop_front();
         if (rsp_tdata[PIXEL_W-1:0] !== want.pixel)
            report_mismatch("pixel_out", rsp_tdata[PIXEL_W-1:0], want.pixel);
         if (rsp_tuser[0] !== want.overlaid)
            report_mismatch("was_overlaid", 16'(rsp_tuser[0]), 16'(want.overlaid));
         if (rsp_tuser[1] !== want.size_error)
            report_mismatch("status", 16'(rsp_tuser[1]), 16'(want.size_error));
         if (rsp_tlast !== want.frame_last)
            report_mismatch("last_of_frame", 16'(rsp_tlast), 16'(want.frame_last));
      end
   endtask

   // Everything is sampled at the rising edge, before the edge's updates land.
   always @(posedge clock) begin
      pixel_outcome_type res;
      if (reset) begin
         ov_width = '0;
         ov_height = '0;
         rep_x = 7'd1;
         rep_y = 7'd1;
         checker_on = 1'b0;
         key_value = '0;
         guard_value = '0;
         sub_x = 0;
         sub_y = 0;
         tile_x = 0;
         tile_y = 0;
         outcomes.delete();
      end else begin
         if (csr_we) load_register(csr_index, csr_wdata);
         if (req_tvalid && req_tready) begin
            if (req_tuser[0] == ACTION_LOAD) begin
               if (32'(req_tdata[11:0]) < OVERLAY_CAPACITY)
                  overlay_mem[req_tdata[11:0]] = req_tdata[27:12];
            end else begin
               predict_pixel(req_tdata[43:28], req_tuser[1], res);
               outcomes.push_back(res);
            end
         end
         if (rsp_tvalid && rsp_tready) check_response();
      end
      pending = outcomes.size();
   end

endmodule

[verif/upscaled_color_key_overlay_unit_tb.sv]
module upscaled_color_key_overlay_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ucko_pkg::*;

   localparam int CAPACITY      = 4096;
   localparam int MAX_REP       = 64;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int SETTLE_CYCLES = 4;
   localparam int STALL_CYCLES  = 300;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_TDATA_W-1:0]  req_tdata = '0;
   logic [REQ_TUSER_W-1:0]  req_tuser = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0]  rsp_tdata;
   logic [RSP_TUSER_W-1:0]  rsp_tuser;
   logic                    rsp_tlast;
   logic                    csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;

   int fail_count;
   int pending;

   // Stimulus bookkeeping.
   bit          steady = 1'b0;
   bit          stall_burst = 1'b0;
   bit          loaded [CAPACITY];
   logic [15:0] cur_key = '0;
   logic [15:0] cur_guard = '0;
   bit          size_ok = 1'b0;
   int          frame_len = 7;
   int          frame_pos = 0;
   int          span = CAPACITY;
   int          requests_sent = 0;
   int          pixels_sent = 0;
   int          settings_count = 0;
   int          cycle_count = 0;

   always #6 clock = ~clock;

   upscaled_color_key_overlay_unit #(
      .OVERLAY_CAPACITY(CAPACITY),
      .MAX_DUP(MAX_REP)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   ucko_overlay_checker #(
      .OVERLAY_CAPACITY(CAPACITY),
      .MAX_DUP(MAX_REP)
   ) overlay_check (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .fail_count(fail_count),
      .pending(pending)
   );

   // Pixel values lean toward the protected value and the signed extremes.
   function automatic logic [15:0] pick_pixel();
      int r;
      r = $urandom_range(0, 9);
      if (r < 2) return cur_guard;
      if (r == 2) return 16'h8000;
      if (r == 3) return 16'h7FFF;
      return 16'($urandom);
   endfunction

   // Overlay entries lean toward the transparent key and the signed extremes.
   function automatic logic [15:0] pick_entry();
      int r;
      r = $urandom_range(0, 9);
      if (r < 2) return cur_key;
      if (r == 2) return 16'h8000;
      if (r == 3) return 16'h7FFF;
      return 16'($urandom);
   endfunction

   // Offers one request, after a random gap unless steady, and waits until it is taken.
   task automatic send_request(input logic action, input logic [11:0] idx,
                               input logic [15:0] ov, input logic [15:0] pix,
                               input logic fs);
      while (!steady && $urandom_range(0, 99) < 29) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {4'b0, pix, ov, idx};
      req_tuser <= {fs, action};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      requests_sent++;
      if (action == ACTION_LOAD) loaded[idx] = 1'b1;
      else pixels_sent++;
   endtask

   // Pixel request with junk in the load fields; tracks the frame position.
   task automatic send_pixel(input logic [15:0] pix, input logic fs);
      send_request(ACTION_PIXEL, 12'($urandom), 16'($urandom), pix, fs);
      if (fs) frame_pos = 0;
      frame_pos++;
      if (frame_pos >= frame_len) frame_pos = 0;
   endtask

   // Holds the request side until every pixel response is back and the pipe is empty.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [15:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // Writes all seven registers while the unit is idle.
   task automatic program_settings(input int w, input int h, input int dx, input int dy,
                                   input int chk, input logic [15:0] key,
                                   input logic [15:0] guard);
      int ex;
      int ey;
      wait_idle();
      write_register(CSR_OVERLAY_WIDTH, 16'(w));
      write_register(CSR_OVERLAY_HEIGHT, 16'(h));
      write_register(CSR_DUP_X, 16'(dx));
      write_register(CSR_DUP_Y, 16'(dy));
      write_register(CSR_CHECKER_MODE, 16'(chk));
      write_register(CSR_TRANSPARENT_KEY, key);
      write_register(CSR_PROTECTED_VALUE, guard);
      csr_we <= 1'b0;
      cur_key = key;
      cur_guard = guard;
      ex = (dx == 0) ? 1 : ((dx > MAX_REP) ? MAX_REP : dx);
      ey = (dy == 0) ? 1 : ((dy > MAX_REP) ? MAX_REP : dy);
      size_ok = !(w == 0 || h == 0 || w > MAX_SIDE || h > MAX_SIDE || w * h > CAPACITY);
      frame_len = size_ok ? w * h * ex * ey : 7;
      span = (w * h >= 1 && w * h <= CAPACITY) ? w * h : CAPACITY;
      settings_count++;
   endtask

   function automatic logic [15:0] pick_special();
      case ($urandom_range(0, 3))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   // One register setting: program it, load the entries the pixels can reach, then
   // stream frames with loads mixed in and the odd early frame start.
   task automatic run_setting(input int w, input int h, input int dx, input int dy,
                              input int chk, input int items, input bit keep,
                              input bit park, input bit steady_on, input bit hold);
      int fill;
      int n;
      logic fs;
      program_settings(w, h, dx, dy, chk, pick_special(), pick_special());
      steady = steady_on;
      // Addresses reached from a frame start never exceed the pixel count.
      fill = 0;
      if (size_ok) fill = (keep || park || w * h < items) ? w * h : items;
      for (n = 0; n < fill; n++) begin
         if (!loaded[n])
            send_request(ACTION_LOAD, 12'(n), pick_entry(), 16'($urandom),
                         1'($urandom_range(0, 1)));
      end
      // Keeping the raster means the first pixel carries no forced frame start.
      frame_pos = keep ? 1 : 0;
      for (n = 0; n < items; n++) begin
         if (hold && n == items / 3) stall_burst = 1'b1;
         if ($urandom_range(0, 99) < 12) begin
            send_request(ACTION_LOAD,
                         $urandom_range(0, 1) ? 12'($urandom_range(0, CAPACITY - 1))
                                              : 12'($urandom_range(0, span - 1)),
                         pick_entry(), 16'($urandom), 1'($urandom_range(0, 1)));
         end else begin
            fs = (frame_pos == 0) || ($urandom_range(0, 39) == 0);
            send_pixel(pick_pixel(), fs);
         end
      end
      // Leave the raster on the frame's last position for the next setting.
      if (park) begin
         while (frame_pos != frame_len - 1) send_pixel(pick_pixel(), 1'b0);
      end
      steady = 1'b0;
   endtask

   // Response side: random back-pressure, none while steady, and a long hold-off in each setting that asks for one.
   initial begin
      int held;
      forever begin
         @(posedge clock);
         if (stall_burst) begin
            rsp_tready <= 1'b0;
            for (held = 0; held < STALL_CYCLES; held++) @(posedge clock);
            stall_burst = 1'b0;
         end else begin
            rsp_tready <= steady || ($urandom_range(0, 99) >= 29);
         end
      end
   end

   // Timeout.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[upscaled_color_key_overlay_unit] ERROR");
      $finish;
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Reset configuration has a zero-sized overlay, so pixels report a size error.
      send_pixel(16'h8000, 1'b1);
      send_pixel(16'h7FFF, 1'b0);
      // A frame start on a load is ignored; the top store address is written too.
      send_request(ACTION_LOAD, 12'd0, 16'h7FFF, 16'h0000, 1'b1);
      send_request(ACTION_LOAD, 12'hFFF, 16'h8000, 16'hFFFF, 1'b0);

      // Small checkerboard overlay with one transparent entry and a protected pixel value.
      program_settings(2, 2, 2, 1, 1, 16'h1234, 16'h8000);
      send_request(ACTION_LOAD, 12'd1, 16'h1234, 16'h0000, 1'b0);
      send_request(ACTION_LOAD, 12'd2, 16'h0000, 16'h0000, 1'b0);
      send_request(ACTION_LOAD, 12'd3, 16'hFFFF, 16'h0000, 1'b0);
      send_pixel(16'h8000, 1'b1);
      send_pixel(16'h0001, 1'b0);
      send_pixel(16'h7FFF, 1'b0);
      send_pixel(16'h5555, 1'b0);
      send_pixel(16'hAAAA, 1'b0);
      send_pixel(16'h8000, 1'b0);
      send_pixel(16'hFFFF, 1'b0);
      send_pixel(16'h0000, 1'b0);

      //          w    h    dx   dy  chk items keep park steady hold
      run_setting(3,   2,   2,   3,   0, 120, 0, 0, 0, 1);
      run_setting(3,   2,   2,   3,   1, 110, 0, 0, 0, 0);
      run_setting(4,   3,   1,   1,   1, 100, 0, 1, 0, 0);
      // Shrinking the overlay mid-frame leaves the raster out of range.
      run_setting(2,   2,   1,   1,   0,  40, 1, 0, 0, 0);
      run_setting(0,   5,   2,   2,   0,  30, 0, 0, 0, 0);
      run_setting(5,   0,   1,   1,   1,  20, 0, 0, 0, 0);
      run_setting(257, 1,   1,   1,   0,  20, 0, 0, 0, 0);
      run_setting(256, 17,  1,   1,   0,  20, 0, 0, 0, 0);
      run_setting(511, 511, 127, 127, 1,  10, 0, 0, 0, 0);
      run_setting(256, 16,  1,   1,   1, 120, 0, 0, 0, 0);
      run_setting(1,   256, 1,   1,   0, 200, 0, 0, 1, 0);
      run_setting(2,   1,   64,  2,   1, 200, 0, 0, 0, 1);
      run_setting(1,   2,   1,   64,  0, 100, 0, 0, 0, 0);
      run_setting(1,   1,   0,   0,   1,  40, 0, 0, 0, 0);
      run_setting(1,   1,   127, 1,   1, 100, 0, 0, 0, 0);
      run_setting(1,   1,   3,   100, 0, 120, 0, 0, 0, 0);
      run_setting(8,   4,   2,   2,   1, 130, 0, 0, 0, 0);

      wait_idle();
      $display("Run covered %0d requests (%0d pixels) under %0d register settings,",
               requests_sent, pixels_sent, settings_count);
      $display("including size errors, clamped replication, checker mode and long stalls.");
      if (fail_count == 0 && pending == 0) begin
         $display("[upscaled_color_key_overlay_unit] OK");
      end else begin
         $display("[upscaled_color_key_overlay_unit] ERROR");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/core/ucko_pkg.sv
rtl/core/ucko_ram.sv
rtl/core/ucko_cfg.sv
rtl/core/ucko_raster.sv
rtl/core/upscaled_color_key_overlay_unit.sv
verif/ucko_overlay_checker.sv
verif/upscaled_color_key_overlay_unit_tb.sv
